@@ hdl/lesf_pkg.sv @@
// Package for the largest empty square finder.
// Holds field widths, configuration register indexes and reset values.
// No dependencies; used by the top level and its checker.
package lesf_pkg;

  // Default sizing of the line buffer and the row counter.
  localparam int unsigned MAX_COLS_DEF = 1024;
  localparam int unsigned MAX_ROWS_DEF = 1024;

  // Field widths fixed by the stream format.
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned SCORE_W  = 11;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned RWIDTH_W = 11;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned CFG_DATA_W  = 11;

  // Saturation value of a square score.
  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_OBSTACLE_CHAR = 1'b0,
    REG_ROW_WIDTH     = 1'b1
  } cfg_reg_t;

  // Register reset values.
  localparam logic [CHAR_W-1:0]   OBSTACLE_RST  = 8'd111;
  localparam logic [RWIDTH_W-1:0] ROW_WIDTH_RST = 11'd1024;

endpackage

@@ hdl/largest_empty_square_finder.sv @@
// Largest empty square finder: streaming maximal-square search over a character map.
// Depends on lesf_pkg; the line buffer is a synchronous memory inside this module.
//
// The block takes one map cell per cycle in raster order unless stalled as below.
// Each cell passes a front stage, where the line buffer is read at the cell's column
// and the row/column counters advance, then a score stage, where the score is formed
// from the buffered score above, the left and the diagonal scores, written back to
// the line buffer and compared against the best so far. A result (size, row, column
// and overflow) is loaded into the output register when the cell marked tlast leaves
// the score stage. The only stall is a result held on the output while out_tready is
// low with another last cell waiting behind it. Configuration is to be written while
// the block is idle, which the block does not enforce; no clearing pass is needed after reset.
module largest_empty_square_finder #(
  parameter int unsigned MAX_COLS = lesf_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS = lesf_pkg::MAX_ROWS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input cells. in_tdata: [7:0] cell_char. in_tlast: last_cell.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [lesf_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                               in_tlast,
  // Results. out_tdata: [10:0] best_size, [20:11] best_row, [30:21] best_col,
  // [31] zero. out_tuser: overflow.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [lesf_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tuser,
  // Configuration writes.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [lesf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned WW    = (COL_W + 1 > lesf_pkg::RWIDTH_W) ? COL_W + 1
                                                                    : lesf_pkg::RWIDTH_W;
  localparam int unsigned SW    = lesf_pkg::SCORE_W;
  localparam int unsigned PW    = lesf_pkg::POS_W;

  // Configuration registers.
  logic [lesf_pkg::CHAR_W-1:0]   obstacle_r;
  logic [lesf_pkg::RWIDTH_W-1:0] row_width_r;

  // Front stage: counters and overflow.
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic             ovf_r;

  // Score stage registers.
  logic             s1_valid_r;
  logic             s1_obst_r;
  logic             s1_first_r;
  logic             s1_last_r;
  logic             s1_rowend_r;
  logic             s1_ovf_r;
  logic [COL_W-1:0] s1_col_r;
  logic [ROW_W-1:0] s1_row_r;
  logic             fwd_r;
  logic [SW-1:0]    fwd_data_r;

  // Neighbor scores and best square.
  logic [SW-1:0]    left_r;
  logic [SW-1:0]    diag_r;
  logic [SW-1:0]    best_size_r;
  logic [ROW_W-1:0] best_row_r;
  logic [COL_W-1:0] best_col_r;

  // Output register.
  logic             out_valid_r;
  logic [SW-1:0]    out_size_r;
  logic [PW-1:0]    out_row_r;
  logic [PW-1:0]    out_col_r;
  logic             out_ovf_r;

  // Line buffer.
  logic [SW-1:0]    lbuf [MAX_COLS];
  logic [SW-1:0]    lbuf_q_r;

  logic             accept;
  logic             s1_adv;
  logic             row_end;
  logic             row_sat;
  logic [WW-1:0]    rw_ext;
  logic [WW-1:0]    eff_width;
  logic [WW-1:0]    col_inc;
  logic [SW-1:0]    up;
  logic [SW-1:0]    min_lu;
  logic [SW-1:0]    min3;
  logic [SW-1:0]    score;
  logic             better;
  logic [SW-1:0]    best_size_nxt;
  logic [ROW_W-1:0] best_row_nxt;
  logic [COL_W-1:0] best_col_nxt;

  // Handshakes. The score stage only waits when a result has nowhere to go.
  assign s1_adv    = s1_valid_r && !(s1_last_r && out_valid_r && !out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obstacle_r  <= lesf_pkg::OBSTACLE_RST;
      row_width_r <= lesf_pkg::ROW_WIDTH_RST;
    end else if (cfg_valid) begin
      case (lesf_pkg::cfg_reg_t'(cfg_index))
        lesf_pkg::REG_OBSTACLE_CHAR: obstacle_r  <= cfg_data[lesf_pkg::CHAR_W-1:0];
        lesf_pkg::REG_ROW_WIDTH:     row_width_r <= cfg_data[lesf_pkg::RWIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective row width: zero acts as one, anything above the buffer depth is clamped.
  always_comb begin
    rw_ext = WW'(row_width_r);
    if (rw_ext == '0) begin
      eff_width = WW'(1);
    end else if (rw_ext > WW'(MAX_COLS)) begin
      eff_width = WW'(MAX_COLS);
    end else begin
      eff_width = rw_ext;
    end
  end

  assign col_inc = WW'(col_r) + WW'(1);
  assign row_end = (col_inc >= eff_width);
  assign row_sat = (row_r == ROW_W'(MAX_ROWS - 1));

  // Front stage: column/row counters and the overflow flag advance on acceptance and clear after the last cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      ovf_r <= 1'b0;
    end else if (accept) begin
      if (in_tlast) begin
        col_r <= '0;
        row_r <= '0;
        ovf_r <= 1'b0;
      end else if (row_end) begin
        col_r <= '0;
        if (row_sat) begin
          ovf_r <= 1'b1;
        end else begin
          row_r <= row_r + ROW_W'(1);
        end
      end else begin
        col_r <= col_inc[COL_W-1:0];
      end
    end
  end

  // Score stage valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Score stage payload, plus forwarding when the cell reads the entry written
  // at the same edge (a row one cell wide).
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_obst_r   <= (in_tdata[lesf_pkg::CHAR_W-1:0] == obstacle_r);
      s1_first_r  <= (row_r == '0) || (col_r == '0);
      s1_last_r   <= in_tlast;
      s1_rowend_r <= row_end;
      s1_ovf_r    <= ovf_r || (row_end && row_sat);
      s1_col_r    <= col_r;
      s1_row_r    <= row_r;
      fwd_r       <= s1_adv && (s1_col_r == col_r);
      fwd_data_r  <= score;
    end
  end

  // Line buffer: one read port for the front stage, one write port for the score stage.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      lbuf[s1_col_r] <= score;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lbuf_q_r <= lbuf[col_r];
    end
  end

  // Score: zero for an obstacle, one in row or column zero, else one above the least neighbor, saturating.
  always_comb begin
    up     = fwd_r ? fwd_data_r : lbuf_q_r;
    min_lu = (up < left_r) ? up : left_r;
    min3   = (min_lu < diag_r) ? min_lu : diag_r;
    if (s1_obst_r) begin
      score = '0;
    end else if (s1_first_r) begin
      score = SW'(1);
    end else if (min3 == lesf_pkg::SCORE_MAX) begin
      score = lesf_pkg::SCORE_MAX;
    end else begin
      score = min3 + SW'(1);
    end
  end

  // Keep the first strictly greatest square.
  always_comb begin
    better        = (score > best_size_r);
    best_size_nxt = better ? score    : best_size_r;
    best_row_nxt  = better ? s1_row_r : best_row_r;
    best_col_nxt  = better ? s1_col_r : best_col_r;
  end

  // Neighbor scores and best square; all return to zero after the last cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= '0;
      diag_r      <= '0;
      best_size_r <= '0;
      best_row_r  <= '0;
      best_col_r  <= '0;
    end else if (s1_adv) begin
      if (s1_last_r) begin
        left_r      <= '0;
        diag_r      <= '0;
        best_size_r <= '0;
        best_row_r  <= '0;
        best_col_r  <= '0;
      end else begin
        left_r      <= s1_rowend_r ? '0 : score;
        diag_r      <= s1_rowend_r ? '0 : up;
        best_size_r <= best_size_nxt;
        best_row_r  <= best_row_nxt;
        best_col_r  <= best_col_nxt;
      end
    end
  end

  // Output register, loaded by the last cell of a map.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_size_r <= best_size_nxt;
      out_row_r  <= PW'(best_row_nxt);
      out_col_r  <= PW'(best_col_nxt);
      out_ovf_r  <= s1_ovf_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_col_r, out_row_r, out_size_r};
  assign out_tuser  = out_ovf_r;

endmodule

@@ hdl/lesf_checker.sv @@
// Port-level checker for the largest empty square finder, with its bind statement.
// Depends on lesf_pkg and on the top level largest_empty_square_finder.
module lesf_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             in_tlast,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [lesf_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // Input back-pressure only comes from a result waiting behind a full output.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a blocked result");

  // A new result follows an accepted last cell that has passed the score stage into the output register.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast, 2))
    else $error("result without a last cell");

  // An empty result carries a zero position.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[10:0] == '0) |-> (out_tdata[30:11] == '0))
    else $error("nonzero position for an empty square");

endmodule

bind largest_empty_square_finder lesf_checker u_lesf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ bench/tb_top.sv @@
// Testbench for largest_empty_square_finder: streams character maps in raster order
// and checks every reported square against a scoring model kept in a scoreboard class.
// Depends on lesf_pkg and the block's top level only.
module tb_top;

  localparam int unsigned COLS          = lesf_pkg::MAX_COLS_DEF;
  localparam int unsigned ROWS          = lesf_pkg::MAX_ROWS_DEF;
  localparam int unsigned SW            = lesf_pkg::SCORE_W;
  localparam int unsigned PW            = lesf_pkg::POS_W;
  localparam int unsigned CW            = lesf_pkg::CHAR_W;
  localparam int unsigned DW            = lesf_pkg::CFG_DATA_W;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned RANDOM_CELLS  = 1300;
  localparam int unsigned RANDOM_MAPS   = 12;
  localparam int unsigned PRESSURE_MAP  = 9;
  localparam int unsigned BURST_CELLS   = 40;

  // One reported square as the block gives it.
  typedef struct packed {
    logic [SW-1:0] side;
    logic [PW-1:0] row;
    logic [PW-1:0] col;
    logic          ovf;
  } square_t;

  // Scores each accepted cell as the block does and keeps the squares still owed.
  class square_tracker;
    bit [CW-1:0]                 obstacle;
    bit [lesf_pkg::RWIDTH_W-1:0] width_reg;
    bit [SW-1:0]                 line_scores [COLS];
    bit [SW-1:0]                 left_sc;
    bit [SW-1:0]                 diag_sc;
    bit [PW-1:0]                 col_pos;
    bit [PW-1:0]                 row_pos;
    square_t                     best;
    int unsigned                 filled;
    int unsigned                 errors;
    square_t                     expected_squares [$];

    function new();
      obstacle  = lesf_pkg::OBSTACLE_RST;
      width_reg = lesf_pkg::ROW_WIDTH_RST;
      filled    = 0;
      errors    = 0;
      foreach (line_scores[i]) line_scores[i] = '0;
      restart_map();
    endfunction

    // The stream state returns to zero after each map; the line buffer does not.
    function void restart_map();
      left_sc = '0;
      diag_sc = '0;
      col_pos = '0;
      row_pos = '0;
      best    = '0;
    endfunction

    function void set_reg(lesf_pkg::cfg_reg_t idx, bit [DW-1:0] value);
      case (idx)
        lesf_pkg::REG_OBSTACLE_CHAR: obstacle = value[CW-1:0];
        lesf_pkg::REG_ROW_WIDTH:     width_reg = value[lesf_pkg::RWIDTH_W-1:0];
        default: ;
      endcase
    endfunction

    // Row length in effect: zero acts as one, anything past the buffer as its size.
    function int unsigned row_cells();
      int unsigned w;
      w = 32'(width_reg);
      if (w == 0) w = 1;
      if (w > COLS) w = COLS;
      return w;
    endfunction

    function void take_cell(bit [CW-1:0] ch, bit last);
      int unsigned w;
      int unsigned j;
      int unsigned up;
      int unsigned score;
      w  = row_cells();
      j  = 32'(col_pos);
      up = 32'(line_scores[col_pos]);
      if (ch == obstacle) begin
        score = 0;
      end else if (row_pos == '0 || j == 0) begin
        score = 1;
      end else begin
        score = up;
        if (32'(left_sc) < score) score = 32'(left_sc);
        if (32'(diag_sc) < score) score = 32'(diag_sc);
        score = score + 1;
        if (score > 32'(lesf_pkg::SCORE_MAX)) score = 32'(lesf_pkg::SCORE_MAX);
      end
      // Only a strictly larger square replaces the one already found.
      if (score > 32'(best.side)) begin
        best.side = SW'(score);
        best.row  = row_pos;
        best.col  = PW'(j);
      end
      diag_sc              = SW'(up);
      left_sc              = SW'(score);
      line_scores[col_pos] = SW'(score);
      if (j + 1 > filled) filled = j + 1;
      // End of row; the row number saturates and flags overflow.
      if (j + 1 >= w) begin
        col_pos = '0;
        left_sc = '0;
        diag_sc = '0;
        if (32'(row_pos) + 1 >= ROWS) best.ovf = 1'b1;
        else row_pos = row_pos + PW'(1);
      end else begin
        col_pos = PW'(j + 1);
      end
      if (last) begin
        expected_squares.push_back(best);
        restart_map();
      end
    endfunction

    function void compare_field(string field, int unsigned want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_square(logic [lesf_pkg::OUT_TDATA_W-1:0] tdata, logic tuser);
      square_t want;
      if (expected_squares.size() == 0) begin
        $error("result with no square owed: tdata %h, tuser %b", tdata, tuser);
        errors++;
      end else begin
        want = expected_squares.pop_front();
        compare_field("best_size", 32'(want.side), 32'(tdata[SW-1:0]));
        compare_field("best_row", 32'(want.row), 32'(tdata[SW +: PW]));
        compare_field("best_col", 32'(want.col), 32'(tdata[SW+PW +: PW]));
        compare_field("overflow", 32'(want.ovf), 32'(tuser));
      end
    endfunction

    function int unsigned pending();
      return expected_squares.size();
    endfunction
  endclass

  logic                                clk;
  logic                                rst_n = 1'b0;
  logic                                in_tvalid = 1'b0;
  logic                                in_tready;
  logic [lesf_pkg::IN_TDATA_W-1:0]     in_tdata = '0;
  logic                                in_tlast = 1'b0;
  logic                                out_tvalid;
  logic                                out_tready = 1'b0;
  logic [lesf_pkg::OUT_TDATA_W-1:0]    out_tdata;
  logic                                out_tuser;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  lesf_pkg::cfg_reg_t                  cfg_index = lesf_pkg::REG_OBSTACLE_CHAR;
  logic [DW-1:0]                       cfg_data = '0;

  int unsigned   sender_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  int unsigned   cells_sent = 0;
  logic          hold_req = 1'b0;
  logic          hold_done = 1'b0;
  square_tracker tracker = new();

  largest_empty_square_finder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

  // Every transaction on either stream goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) tracker.take_cell(in_tdata[CW-1:0], in_tlast);
      if (out_tvalid && out_tready) tracker.check_square(out_tdata, out_tuser);
    end
  end

  // Result sink: random back-pressure, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done <= 1'b1;
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_cell(logic [CW-1:0] ch, logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    cells_sent++;
  endtask

  task automatic stop_input();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_results();
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic program_reg(lesf_pkg::cfg_reg_t idx, logic [DW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CW-1:0] free_char();
    logic [CW-1:0] c;
    do c = CW'($urandom_range(255)); while (c == tracker.obstacle);
    return c;
  endfunction

  function automatic logic [CW-1:0] map_cell(int unsigned free_pct);
    if ($urandom_range(99) < free_pct) return free_char();
    return tracker.obstacle;
  endfunction

  // Change the settings in the middle of a map once the last cell has settled.
  // A wider row may only reach line buffer entries that already hold a score.
  task automatic reshape_mid_map();
    int unsigned               reach;
    int unsigned               eff;
    logic [DW-1:0]             wval;
    stop_input();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    reach = (tracker.filled < 12) ? tracker.filled : 12;
    eff   = $urandom_range(reach, 1);
    wval  = (eff == 1 && $urandom_range(1)) ? '0 : DW'(eff);
    program_reg(lesf_pkg::REG_ROW_WIDTH, wval);
    if ($urandom_range(1)) program_reg(lesf_pkg::REG_OBSTACLE_CHAR, DW'($urandom_range(2047)));
  endtask

  task automatic send_map(int unsigned n_cells, int unsigned free_pct, int change_at);
    for (int k = 0; k < n_cells; k++) begin
      if (k == change_at) reshape_mid_map();
      send_cell(map_cell(free_pct), k == n_cells - 1);
    end
  endtask

  // New settings between maps, extremes included.
  task automatic new_settings();
    logic [DW-1:0] wval;
    logic [CW-1:0] obs;
    case ($urandom_range(9))
      0:       wval = '0;
      1:       wval = DW'($urandom_range(40, 9));
      2:       wval = DW'($urandom_range(2047, 1000));
      default: wval = DW'($urandom_range(8, 1));
    endcase
    case ($urandom_range(7))
      0:       obs = '0;
      1:       obs = '1;
      default: obs = CW'($urandom_range(255));
    endcase
    program_reg(lesf_pkg::REG_ROW_WIDTH, wval);
    program_reg(lesf_pkg::REG_OBSTACLE_CHAR, {3'($urandom_range(7)), obs});
  endtask

  // A small random map; wide rows only get a short map inside the first row.
  task automatic random_map();
    int unsigned eff;
    int unsigned n;
    int          change_at;
    eff = tracker.row_cells();
    n   = eff * $urandom_range(6, 1);
    if (eff > 40) n = $urandom_range(40, 1);
    else if ($urandom_range(4) == 0) n = $urandom_range(n, 1);
    change_at = -1;
    if (n >= 3 && $urandom_range(7) == 0) change_at = $urandom_range(n - 2, 1);
    send_map(n, $urandom_range(100, 60), change_at);
  endtask

  initial begin
    sender_idle_pct <= 32;
    recv_idle_pct   <= 56;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: a map cut short in its first row, then a map of one blocked cell.
    send_cell(8'h00, 1'b0);
    send_cell(8'hFF, 1'b0);
    send_cell(lesf_pkg::OBSTACLE_RST, 1'b0);
    send_cell(8'h55, 1'b0);
    send_cell(8'hAA, 1'b1);
    send_cell(lesf_pkg::OBSTACLE_RST, 1'b1);
    stop_input();
    wait_results();

    // A fully free three by three map; upper data bits of the obstacle are ignored.
    program_reg(lesf_pkg::REG_OBSTACLE_CHAR, 11'h700);
    program_reg(lesf_pkg::REG_ROW_WIDTH, 11'd3);
    send_map(9, 100, -1);
    stop_input();
    wait_results();

    // Width set to zero in the second row: the current row ends after the next cell.
    for (int k = 0; k < 4; k++) send_cell(8'h2E, 1'b0);
    stop_input();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    program_reg(lesf_pkg::REG_ROW_WIDTH, 11'd0);
    send_cell(8'h2E, 1'b0);
    send_cell(8'h00, 1'b0);
    send_cell(8'h2E, 1'b1);
    stop_input();
    wait_results();

    // Random maps; the first is a long one for row overflow, the second uses a row
    // width far past the buffer depth.
    cells_sent = 0;
    for (int m = 0; m < RANDOM_MAPS || cells_sent < RANDOM_CELLS; m++) begin
      if (m == RANDOM_MAPS / 3) begin
        sender_idle_pct <= 56;
        recv_idle_pct   <= 32;
      end
      if (m == 2 * RANDOM_MAPS / 3) begin
        sender_idle_pct <= 0;
        recv_idle_pct   <= 0;
      end
      if (m == 0) begin
        program_reg(lesf_pkg::REG_ROW_WIDTH, DW'($urandom_range(1)));
        program_reg(lesf_pkg::REG_OBSTACLE_CHAR, 11'd255);
        send_map($urandom_range(1030, 1023), 90, -1);
      end else if (m == 1) begin
        program_reg(lesf_pkg::REG_ROW_WIDTH, 11'd2047);
        send_map($urandom_range(40, 1), 85, -1);
      end else if (m == PRESSURE_MAP) begin
        // Tiny maps keep coming while the sink holds off, so the block must stall.
        hold_req <= 1'b1;
        for (int k = 0; k < BURST_CELLS; k++) begin
          send_cell(map_cell(70), k == BURST_CELLS - 1 || $urandom_range(3) != 0);
        end
        while (!hold_done) @(posedge clk);
      end else begin
        if ($urandom_range(1)) new_settings();
        random_map();
      end
      stop_input();
      wait_results();
    end

    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/lesf_pkg.sv
hdl/largest_empty_square_finder.sv
hdl/lesf_checker.sv
bench/tb_top.sv
